// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: property does not hold");
// Check that a boolean condition is never seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- design/bis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Sizes, codes and sequencer states shared by the scaler RTL.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Field and size widths
  localparam int SRC_W     = 9;   // source size, 1..256
  localparam int DST_W     = 11;  // destination size, 1..1024
  localparam int COORD_W   = 10;  // destination coordinate
  localparam int FRAC_BITS = 8;   // fraction of the source position
  localparam int ADDR_W    = 16;  // pixel store address
  localparam int PIX_W     = 24;  // packed RGB pixel
  localparam int STEP_W    = 4;   // sequencer step counter

  localparam int STORE_DEPTH = 1 << ADDR_W;

  localparam logic [SRC_W-1:0]     MAX_SRC_DIM = SRC_W'(256);
  localparam logic [DST_W-1:0]     MAX_DST_DIM = DST_W'(1024);
  localparam logic [FRAC_BITS:0]   WGT_ONE     = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // Configuration register indexes
  localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_DST_HEIGHT = 2'd3;

  // Transaction kinds carried on tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Last step of each multi-cycle sequencer phase
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(15);
  localparam logic [STEP_W-1:0] BASE_LAST = STEP_W'(1);
  localparam logic [STEP_W-1:0] WGT_LAST  = STEP_W'(3);
  localparam logic [STEP_W-1:0] MAC_LAST  = STEP_W'(11);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_ROW,
    ST_BASE,
    ST_WGT,
    ST_MAC,
    ST_OUT
  } state_t;

endpackage

// ----- design/bilinear_image_scaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Stores an RGB source image and answers destination pixel queries with
// bilinearly interpolated colour.
// ----------------------------------------------------------------------------
// A load transaction (tuser = 0) writes the next source pixel in raster order
// without leaving the idle state; the write position wraps to zero after the
// last pixel of the configured image, and a load found past the image only
// resets the position. A query transaction (tuser = 1) returns one result, and
// no new transaction is accepted until the sequencer is back in idle. In the
// sequencer, one bit-serial restoring divider runs 16 steps for each axis,
// and one shared 17x9 multiplier is used for the two position products, the
// two row bases, the four weights and the twelve weight-pixel products (four
// per channel). The four neighbour pixels are read from the store's registered
// read port while the weights are formed. The result sits in an output
// register, so a new transaction is taken while it waits.
// Write the size registers only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_image_scaler (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_red [7:0], in_green [15:8], in_blue [23:16], dest_col [33:24],
  // dest_row [43:34], zero [47:44]
  input  logic [47:0] in_tdata,
  // command [0]
  input  logic        in_tuser,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_red [7:0], out_green [15:8], out_blue [23:16]
  output logic [23:0] out_tdata,
  // Configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [10:0] cfg_wr_data
);

  localparam int SW = bis_pkg::SRC_W;
  localparam int DW = bis_pkg::DST_W;
  localparam int CW = bis_pkg::COORD_W;
  localparam int FB = bis_pkg::FRAC_BITS;
  localparam int AW = bis_pkg::ADDR_W;
  localparam int PW = bis_pkg::PIX_W;
  localparam int TW = bis_pkg::STEP_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SW-1:0] src_width_r, src_height_r;
  logic [DW-1:0] dst_width_r, dst_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= bis_pkg::MAX_SRC_DIM;
      src_height_r <= bis_pkg::MAX_SRC_DIM;
      dst_width_r  <= DW'(256);
      dst_height_r <= DW'(256);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        bis_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wr_data[SW-1:0];
        bis_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wr_data[SW-1:0];
        bis_pkg::CFG_DST_WIDTH:  dst_width_r  <= cfg_wr_data;
        bis_pkg::CFG_DST_HEIGHT: dst_height_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Saturate the sizes to their legal ranges: zero acts as one
  logic [SW-1:0] sw, sh, sw_m1, sh_m1;
  logic [DW-1:0] dw, dh, dw_m1, dh_m1;

  assign sw = (src_width_r == '0) ? SW'(1) :
              (src_width_r > bis_pkg::MAX_SRC_DIM) ? bis_pkg::MAX_SRC_DIM : src_width_r;
  assign sh = (src_height_r == '0) ? SW'(1) :
              (src_height_r > bis_pkg::MAX_SRC_DIM) ? bis_pkg::MAX_SRC_DIM : src_height_r;
  assign dw = (dst_width_r == '0) ? DW'(1) :
              (dst_width_r > bis_pkg::MAX_DST_DIM) ? bis_pkg::MAX_DST_DIM : dst_width_r;
  assign dh = (dst_height_r == '0) ? DW'(1) :
              (dst_height_r > bis_pkg::MAX_DST_DIM) ? bis_pkg::MAX_DST_DIM : dst_height_r;
  assign sw_m1 = sw - SW'(1);
  assign sh_m1 = sh - SW'(1);
  assign dw_m1 = dw - DW'(1);
  assign dh_m1 = dh - DW'(1);

  // --------------------------------------------------------------------------
  // Input field unpacking
  // --------------------------------------------------------------------------
  logic [7:0]    in_red, in_green, in_blue;
  logic [CW-1:0] in_col, in_row, col_clamped, row_clamped;
  logic [PW-1:0] load_pixel;

  assign in_red   = in_tdata[7:0];
  assign in_green = in_tdata[15:8];
  assign in_blue  = in_tdata[23:16];
  assign in_col   = in_tdata[33:24];
  assign in_row   = in_tdata[43:34];

  // Store holds red in the high byte, blue in the low byte
  assign load_pixel = {in_red, in_green, in_blue};

  // Clamp the query to the destination image
  assign col_clamped = ({1'b0, in_col} > dw_m1) ? dw_m1[CW-1:0] : in_col;
  assign row_clamped = ({1'b0, in_row} > dh_m1) ? dh_m1[CW-1:0] : in_row;

  // --------------------------------------------------------------------------
  // Load position
  // --------------------------------------------------------------------------
  logic [AW-1:0] load_pos_r, load_pos_nxt;
  logic [AW:0]   total, pos_inc;
  logic          pos_ok, load_we;

  assign total   = (AW+1)'(sw) * (AW+1)'(sh);
  assign pos_ok  = {1'b0, load_pos_r} < total;
  assign pos_inc = {1'b0, load_pos_r} + (AW+1)'(1);

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  bis_pkg::state_t state_r, state_nxt;
  logic [TW-1:0]   step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            rd_pend_r, rd_pend_nxt;
  logic [1:0]      rd_idx_r;
  logic            in_accept, out_load;

  // Payload registers
  logic [CW-1:0] x_r, y_r;
  logic [DW-1:0] div_rem_r;
  logic [15:0]   div_q_r;
  logic [7:0]    x1_r, x2_r, y1_r, y2_r, ax_r, ay_r;
  logic [AW-1:0] row1_r, row2_r;
  logic [16:0]   w_r [4];
  logic [PW-1:0] pix_r [4];
  logic [23:0]   acc_r;
  logic [PW-1:0] res_r, out_data_r;
  logic [PW-1:0] mem_q_r;

  // --------------------------------------------------------------------------
  // Shared multiplier: operands chosen by the sequencer phase
  // --------------------------------------------------------------------------
  logic [16:0] mul_a;
  logic [8:0]  mul_b;
  logic [25:0] mul_p;
  logic [1:0]  k;        // neighbour: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
  logic [1:0]  chan;     // 0 red, 1 green, 2 blue
  logic [FB:0] wx0, wx1, wy0, wy1;
  logic [7:0]  chan_val;

  assign k    = step_r[1:0];
  assign chan = step_r[3:2];
  assign wx0  = bis_pkg::WGT_ONE - (FB+1)'(ax_r);
  assign wx1  = (FB+1)'(ax_r);
  assign wy0  = bis_pkg::WGT_ONE - (FB+1)'(ay_r);
  assign wy1  = (FB+1)'(ay_r);

  always_comb begin
    case (chan)
      2'd0:    chan_val = pix_r[k][23:16];
      2'd1:    chan_val = pix_r[k][15:8];
      2'd2:    chan_val = pix_r[k][7:0];
      default: chan_val = 8'h00;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      bis_pkg::ST_MULX: begin
        mul_a = 17'(x_r);
        mul_b = sw;
      end
      bis_pkg::ST_MULY: begin
        mul_a = 17'(y_r);
        mul_b = sh;
      end
      bis_pkg::ST_BASE: begin
        mul_a = 17'(step_r[0] ? y2_r : y1_r);
        mul_b = sw;
      end
      bis_pkg::ST_WGT: begin
        mul_a = 17'(k[0] ? wx1 : wx0);
        mul_b = k[1] ? wy1 : wy0;
      end
      bis_pkg::ST_MAC: begin
        mul_a = w_r[k];
        mul_b = {1'b0, chan_val};
      end
      default: ;
    endcase
  end

  assign mul_p = 26'(mul_a) * 26'(mul_b);

  // Accumulate the four weighted neighbours of one channel
  logic [23:0] acc_sum;
  assign acc_sum = ((k == 2'd0) ? 24'd0 : acc_r) + mul_p[23:0];

  // --------------------------------------------------------------------------
  // Shared restoring divider: one quotient bit per cycle.
  // The dividend is pos*size << FRAC_BITS, so the 16-bit quotient holds the
  // integer part in its high byte and the fraction in its low byte.
  // --------------------------------------------------------------------------
  logic [DW-1:0] div_den, div_rem_nxt;
  logic [DW:0]   div_trial, div_diff;
  logic          div_ge;

  assign div_den     = (state_r == bis_pkg::ST_DIVY) ? dh : dw;
  assign div_trial   = {div_rem_r, div_q_r[15]};
  assign div_ge      = div_trial >= {1'b0, div_den};
  assign div_diff    = div_trial - {1'b0, div_den};
  assign div_rem_nxt = div_ge ? div_diff[DW-1:0] : div_trial[DW-1:0];

  // Split the finished quotient; clamp the neighbour pair to the image edge
  logic [SW-1:0] pos_lim;
  logic [7:0]    pos_i, pos_i1, pos_i2;
  logic [SW-1:0] pos_inc1;

  assign pos_lim  = (state_r == bis_pkg::ST_ROW) ? sh_m1 : sw_m1;
  assign pos_i    = ({1'b0, div_q_r[15:8]} > pos_lim) ? pos_lim[7:0] : div_q_r[15:8];
  assign pos_inc1 = {1'b0, pos_i} + SW'(1);
  assign pos_i1   = pos_inc1[7:0];
  assign pos_i2   = (pos_inc1 <= pos_lim) ? pos_i1 : pos_lim[7:0];

  // Store read address for the neighbour being fetched
  logic [AW-1:0] rd_addr;
  assign rd_addr = (k[1] ? row2_r : row1_r) + AW'(k[0] ? x2_r : x1_r);

  // --------------------------------------------------------------------------
  // Sequencer: next state and handshake
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    in_tready     = 1'b0;
    in_accept     = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    load_pos_nxt  = load_pos_r;
    rd_pend_nxt   = (state_r == bis_pkg::ST_WGT);
    case (state_r)
      bis_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        in_accept = in_tvalid;
        if (in_accept && in_tuser == bis_pkg::CMD_QUERY) begin
          state_nxt = bis_pkg::ST_MULX;
        end else if (in_accept) begin
          // At or past the last pixel restart at the first entry; a load past the image is dropped
          if (!pos_ok || pos_inc >= total) begin
            load_pos_nxt = '0;
          end else begin
            load_pos_nxt = pos_inc[AW-1:0];
          end
        end
      end
      bis_pkg::ST_MULX: begin
        state_nxt = bis_pkg::ST_DIVX;
        step_nxt  = '0;
      end
      bis_pkg::ST_DIVX: begin
        step_nxt = step_r + TW'(1);
        if (step_r == bis_pkg::DIV_LAST) begin
          state_nxt = bis_pkg::ST_MULY;
          step_nxt  = '0;
        end
      end
      bis_pkg::ST_MULY: begin
        state_nxt = bis_pkg::ST_DIVY;
        step_nxt  = '0;
      end
      bis_pkg::ST_DIVY: begin
        step_nxt = step_r + TW'(1);
        if (step_r == bis_pkg::DIV_LAST) begin
          state_nxt = bis_pkg::ST_ROW;
          step_nxt  = '0;
        end
      end
      bis_pkg::ST_ROW: begin
        state_nxt = bis_pkg::ST_BASE;
        step_nxt  = '0;
      end
      bis_pkg::ST_BASE: begin
        step_nxt = step_r + TW'(1);
        if (step_r == bis_pkg::BASE_LAST) begin
          state_nxt = bis_pkg::ST_WGT;
          step_nxt  = '0;
        end
      end
      bis_pkg::ST_WGT: begin
        step_nxt = step_r + TW'(1);
        if (step_r == bis_pkg::WGT_LAST) begin
          state_nxt = bis_pkg::ST_MAC;
          step_nxt  = '0;
        end
      end
      bis_pkg::ST_MAC: begin
        step_nxt = step_r + TW'(1);
        if (step_r == bis_pkg::MAC_LAST) begin
          state_nxt = bis_pkg::ST_OUT;
          step_nxt  = '0;
        end
      end
      bis_pkg::ST_OUT: begin
        // Hold the finished result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bis_pkg::ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  assign load_we = in_accept && (in_tuser == bis_pkg::CMD_LOAD) && pos_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bis_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      load_pos_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      load_pos_r  <= load_pos_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    rd_idx_r <= k;
    // Capture each neighbour from the registered read data in the cycle after its read
    if (rd_pend_r) begin
      pix_r[rd_idx_r] <= mem_q_r;
    end
    case (state_r)
      bis_pkg::ST_IDLE: begin
        if (in_accept && in_tuser == bis_pkg::CMD_QUERY) begin
          x_r <= col_clamped;
          y_r <= row_clamped;
        end
      end
      bis_pkg::ST_MULX, bis_pkg::ST_MULY: begin
        // Seed the divider with the product shifted up by the fraction width
        div_rem_r <= DW'(mul_p[17:8]);
        div_q_r   <= {mul_p[7:0], 8'h00};
        if (state_r == bis_pkg::ST_MULY) begin
          x1_r <= pos_i;
          x2_r <= pos_i2;
          ax_r <= div_q_r[FB-1:0];
        end
      end
      bis_pkg::ST_DIVX, bis_pkg::ST_DIVY: begin
        div_rem_r <= div_rem_nxt;
        div_q_r   <= {div_q_r[14:0], div_ge};
      end
      bis_pkg::ST_ROW: begin
        y1_r <= pos_i;
        y2_r <= pos_i2;
        ay_r <= div_q_r[FB-1:0];
      end
      bis_pkg::ST_BASE: begin
        if (step_r[0]) begin
          row2_r <= mul_p[AW-1:0];
        end else begin
          row1_r <= mul_p[AW-1:0];
        end
      end
      bis_pkg::ST_WGT: begin
        w_r[k] <= mul_p[16:0];
      end
      bis_pkg::ST_MAC: begin
        acc_r <= acc_sum;
        // Last neighbour of a channel: keep sum >> 16
        if (k == 2'd3) begin
          case (chan)
            2'd0:    res_r[7:0]   <= acc_sum[23:16];
            2'd1:    res_r[15:8]  <= acc_sum[23:16];
            default: res_r[23:16] <= acc_sum[23:16];
          endcase
        end
      end
      bis_pkg::ST_OUT: begin
        if (out_load) begin
          out_data_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pixel store: one write port for loads, one registered read port
  // --------------------------------------------------------------------------
  logic [PW-1:0] store_mem [0:bis_pkg::STORE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (load_we) begin
      store_mem[load_pos_r] <= load_pixel;
    end
  end

  always_ff @(posedge clk) begin
    mem_q_r <= store_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_query_starts, clk, rst_n,
    (in_tvalid && in_tready && in_tuser == bis_pkg::CMD_QUERY) |=> (state_r == bis_pkg::ST_MULX))
  `ASSERT_ALWAYS(a_result_from_seq, clk, rst_n,
    $rose(out_valid_r) |-> $past(state_r == bis_pkg::ST_OUT))
  `ASSERT_NEVER(a_wgt_step_range, clk, rst_n,
    (state_r == bis_pkg::ST_WGT) && (step_r > bis_pkg::WGT_LAST))
  `ASSERT_ALWAYS(a_mac_to_out, clk, rst_n,
    (state_r == bis_pkg::ST_MAC && step_r == bis_pkg::MAC_LAST) |=> (state_r == bis_pkg::ST_OUT))

endmodule

// ----- verif/tb_bilinear_image_scaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler testbench
// Loads source images of many shapes, queries destination pixels and checks
// every returned colour against a bit-exact interpolation predictor, under
// random source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_bilinear_image_scaler;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // One pending input transaction: kind for tuser, packed fields for tdata
  typedef struct packed {
    logic        kind;
    logic [47:0] payload;
  } scaler_txn_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [10:0] cfg_wr_data;

  scaler_txn_t pending_txns[$];
  logic [23:0] expected_pixels[$];
  logic        in_taken;
  idle_mode_t  idle_mode;
  int          err_count;

  // Predictor state: shadow copy of the source image and size registers
  logic [23:0] src_image [0:bis_pkg::STORE_DEPTH-1];
  int unsigned load_ptr;
  logic [8:0]  reg_src_w, reg_src_h;
  logic [10:0] reg_dst_w, reg_dst_h;

  bilinear_image_scaler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Sizes are used saturated to 1..maximum, so zero acts as one
  function automatic int unsigned sat_dim(int unsigned v, int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned image_pixels();
    return sat_dim(reg_src_w, bis_pkg::MAX_SRC_DIM) *
           sat_dim(reg_src_h, bis_pkg::MAX_SRC_DIM);
  endfunction

  // Raster-order write; a load found past the image only rewinds the pointer
  task automatic store_pixel(logic [23:0] px);
    int unsigned total;
    total = image_pixels();
    if (load_ptr < total) begin
      src_image[load_ptr] = px;
      load_ptr++;
      if (load_ptr >= total) load_ptr = 0;
    end else begin
      load_ptr = 0;
    end
  endtask

  // Colour of one destination pixel; channel c sits at bits 8c+7:8c
  function automatic logic [23:0] interpolate(logic [9:0] col, logic [9:0] row);
    int unsigned sw, sh, dw, dh, x, y, x0, y0, x1, y1, fx, fy;
    int unsigned top, bot, acc, ch, unit;
    logic [23:0] p00, p01, p10, p11, res;
    sw = sat_dim(reg_src_w, bis_pkg::MAX_SRC_DIM);
    sh = sat_dim(reg_src_h, bis_pkg::MAX_SRC_DIM);
    dw = sat_dim(reg_dst_w, bis_pkg::MAX_DST_DIM);
    dh = sat_dim(reg_dst_h, bis_pkg::MAX_DST_DIM);
    unit = 1 << bis_pkg::FRAC_BITS;
    x = col;
    y = row;
    if (x > dw - 1) x = dw - 1;
    if (y > dh - 1) y = dh - 1;
    x0 = (x * sw) / dw;
    fx = (((x * sw) % dw) << bis_pkg::FRAC_BITS) / dw;
    y0 = (y * sh) / dh;
    fy = (((y * sh) % dh) << bis_pkg::FRAC_BITS) / dh;
    if (x0 > sw - 1) x0 = sw - 1;
    if (y0 > sh - 1) y0 = sh - 1;
    // Right and bottom neighbours stop at the image edge
    x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
    y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
    p00 = src_image[(y0 * sw + x0) % bis_pkg::STORE_DEPTH];
    p01 = src_image[(y0 * sw + x1) % bis_pkg::STORE_DEPTH];
    p10 = src_image[(y1 * sw + x0) % bis_pkg::STORE_DEPTH];
    p11 = src_image[(y1 * sw + x1) % bis_pkg::STORE_DEPTH];
    for (ch = 0; ch < 3; ch++) begin
      top = (unit - fx) * p00[8*ch +: 8] + fx * p01[8*ch +: 8];
      bot = (unit - fx) * p10[8*ch +: 8] + fx * p11[8*ch +: 8];
      acc = ((unit - fy) * top + fy * bot) >> (2 * bis_pkg::FRAC_BITS);
      if (acc > 255) acc = 255;
      res[8*ch +: 8] = 8'(acc);
    end
    return res;
  endfunction

  // Accept side: track handshakes and advance the predictor on each one
  always @(posedge clk) begin : in_monitor
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == bis_pkg::CMD_LOAD) begin
        store_pixel(in_tdata[23:0]);
      end else begin
        expected_pixels.push_back(interpolate(in_tdata[33:24], in_tdata[43:34]));
      end
    end
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  // Driver: present the next transaction at the falling edge once the
  // previous one has gone; drop valid while the sender idles
  always @(negedge clk) begin : in_driver
    scaler_txn_t txn;
    logic        rest;
    rest = ((idle_mode == IDLE_SEND) && ($urandom_range(0, 99) < 64)) ||
           ((idle_mode == IDLE_BOTH) && ($urandom_range(0, 99) < 9));
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_txns.size() != 0 && !rest) begin
        txn = pending_txns.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= txn.kind;
        in_tdata  <= txn.payload;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Sink back-pressure
  always @(negedge clk) begin : out_driver
    if (rst_n) begin
      out_tready <= !(((idle_mode == IDLE_RECV) && ($urandom_range(0, 99) < 64)) ||
                      ((idle_mode == IDLE_BOTH) && ($urandom_range(0, 99) < 9)));
    end
  end

  // Result checker: compare each transaction with the oldest expectation
  always @(posedge clk) begin : out_monitor
    logic [23:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %06h", $time, out_tdata);
        err_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata[7:0] !== want[7:0]) begin
          $display("%0t: out_red mismatch, expected %0d, actual %0d",
                   $time, want[7:0], out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[15:8] !== want[15:8]) begin
          $display("%0t: out_green mismatch, expected %0d, actual %0d",
                   $time, want[15:8], out_tdata[15:8]);
          err_count++;
        end
        if (out_tdata[23:16] !== want[23:16]) begin
          $display("%0t: out_blue mismatch, expected %0d, actual %0d",
                   $time, want[23:16], out_tdata[23:16]);
          err_count++;
        end
      end
    end
  end

  function automatic scaler_txn_t load_txn(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    scaler_txn_t t;
    t.kind    = bis_pkg::CMD_LOAD;
    t.payload = {24'd0, b, g, r};
    return t;
  endfunction

  function automatic scaler_txn_t query_txn(logic [9:0] col, logic [9:0] row);
    scaler_txn_t t;
    t.kind    = bis_pkg::CMD_QUERY;
    t.payload = {4'd0, row, col, 24'd0};
    return t;
  endfunction

  function automatic scaler_txn_t random_load();
    logic [23:0] px;
    px = $urandom;
    // Now and then a flat black or white pixel
    if ($urandom_range(0, 7) == 0) px = {24{1'($urandom_range(0, 1))}};
    return load_txn(px[7:0], px[15:8], px[23:16]);
  endfunction

  // Mostly inside the destination, sometimes on its edge or far outside
  function automatic logic [9:0] pick_coord(int unsigned dim);
    case ($urandom_range(0, 9))
      0: return 10'($urandom_range(0, 1023));
      1: return 10'(dim - 1);
      2: return 10'd0;
      default: return 10'($urandom_range(0, dim - 1));
    endcase
  endfunction

  // Register write; only called while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [10:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= value;
    case (idx)
      bis_pkg::CFG_SRC_WIDTH:  reg_src_w = value[8:0];
      bis_pkg::CFG_SRC_HEIGHT: reg_src_h = value[8:0];
      bis_pkg::CFG_DST_WIDTH:  reg_dst_w = value;
      bis_pkg::CFG_DST_HEIGHT: reg_dst_h = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh);
    write_reg(bis_pkg::CFG_SRC_WIDTH, 11'(sw));
    write_reg(bis_pkg::CFG_SRC_HEIGHT, 11'(sh));
    write_reg(bis_pkg::CFG_DST_WIDTH, 11'(dw));
    write_reg(bis_pkg::CFG_DST_HEIGHT, 11'(dh));
  endtask

  // Hold until every transaction is in and every result out, then let the
  // longest query sequence run out before the next register write
  task automatic settle();
    while (pending_txns.size() != 0 || in_tvalid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Queue loads that cover the whole image from the current write position:
  // one ignored load if the position is past the image, the remainder up to
  // the wrap, then a complete fresh image
  task automatic fill_image();
    int unsigned total, n;
    total = image_pixels();
    n = total;
    if (load_ptr >= total) n = n + 1;
    else if (load_ptr != 0) n = n + total - load_ptr;
    repeat (n) pending_txns.push_back(random_load());
  endtask

  task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh, idle_mode_t mode, int unsigned n);
    int unsigned dwe, dhe;
    set_sizes(sw, sh, dw, dh);
    idle_mode = mode;
    fill_image();
    dwe = sat_dim(reg_dst_w, bis_pkg::MAX_DST_DIM);
    dhe = sat_dim(reg_dst_h, bis_pkg::MAX_DST_DIM);
    // Queries with loads mixed in; the image stays fully written throughout
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) pending_txns.push_back(random_load());
      else pending_txns.push_back(query_txn(pick_coord(dwe), pick_coord(dhe)));
    end
    settle();
  endtask

  initial begin : time_limit
    #10_000_000;
    $display("[bilinear_image_scaler] ERROR");
    $finish;
  end

  initial begin : stimulus
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = bis_pkg::CMD_LOAD;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_addr    = bis_pkg::CFG_SRC_WIDTH;
    cfg_wr_data = '0;
    in_taken    = 1'b0;
    idle_mode   = IDLE_NONE;
    err_count   = 0;
    load_ptr    = 0;
    reg_src_w   = 9'd256;
    reg_src_h   = 9'd256;
    reg_dst_w   = 11'd256;
    reg_dst_h   = 11'd256;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: 2x2 source of extreme colours scaled to 3x5, corners,
    // interior points and queries clamped from far outside the destination
    set_sizes(2, 2, 3, 5);
    pending_txns.push_back(load_txn(8'hFF, 8'h00, 8'hFF));
    pending_txns.push_back(load_txn(8'h00, 8'hFF, 8'h00));
    pending_txns.push_back(load_txn(8'hFF, 8'hFF, 8'hFF));
    pending_txns.push_back(load_txn(8'h00, 8'h00, 8'h00));
    pending_txns.push_back(query_txn(10'd0, 10'd0));
    pending_txns.push_back(query_txn(10'd1, 10'd1));
    pending_txns.push_back(query_txn(10'd2, 10'd4));
    pending_txns.push_back(query_txn(10'd1, 10'd3));
    pending_txns.push_back(query_txn(10'd1023, 10'd1023));
    pending_txns.push_back(query_txn(10'd1023, 10'd0));
    pending_txns.push_back(query_txn(10'd0, 10'd1023));
    settle();

    // Directed: 4x2 image, then five extra loads leave the write position
    // at five, past the end of the 2x2 image set next
    set_sizes(4, 2, 7, 3);
    fill_image();
    repeat (5) pending_txns.push_back(random_load());
    pending_txns.push_back(query_txn(10'd6, 10'd2));
    pending_txns.push_back(query_txn(10'd3, 10'd1));
    settle();

    // Directed: shrunk image, so the first load is ignored and rewinds;
    // a 1x1 destination clamps every query to the origin
    set_sizes(2, 2, 1, 1);
    fill_image();
    pending_txns.push_back(query_txn(10'd0, 10'd0));
    pending_txns.push_back(query_txn(10'd1023, 10'd1023));
    settle();

    // Random phases over many shapes, extremes and out-of-range sizes
    run_phase(511, 1, 2047, 2, IDLE_SEND, 40);
    run_phase(1, 9, 1, 1024, IDLE_RECV, 40);
    run_phase(0, 0, 0, 0, IDLE_BOTH, 30);
    run_phase(5, 7, 13, 11, IDLE_NONE, 40);
    run_phase(3, 4, 700, 600, IDLE_BOTH, 30);

    if (err_count == 0 && expected_pixels.size() == 0) begin
      $display("[bilinear_image_scaler] OK");
    end else begin
      $display("[bilinear_image_scaler] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/bis_pkg.sv
design/bilinear_image_scaler.sv
verif/tb_bilinear_image_scaler.sv
